/* rtl/htfe_pkg.sv */
// package for the header/trailer frame extractor
// holds result and push types, register codes, size and reset constants; no dependencies
package htfe_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);

  localparam logic [15:0] HEADER_RST  = 16'h5AA5;
  localparam logic [15:0] TRAILER_RST = 16'hA55A;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t REG_HEADER  = 1'b0;
  localparam cfg_idx_t REG_TRAILER = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] byte_position;
    logic       frame_done;
    logic [8:0] frame_length;
    logic       frame_abort;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

/* rtl/htfe_in_if.sv */
// byte input channel of the frame extractor
// valid/ready handshake with the received byte; no dependencies
interface htfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/htfe_out_if.sv */
// result channel of the frame extractor
// valid/ready handshake with one frame result item; no dependencies
interface htfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [7:0] byte_position;
  logic       frame_done;
  logic [8:0] frame_length;
  logic       frame_abort;
  logic       run_last;

  modport source (
    output valid, output frame_byte, output byte_position, output frame_done,
    output frame_length, output frame_abort, output run_last, input ready
  );
  modport sink (
    input valid, input frame_byte, input byte_position, input frame_done,
    input frame_length, input frame_abort, input run_last, output ready
  );
endinterface

/* rtl/header_tail_frame_extractor_unit.sv */
// top level of the header/trailer frame extractor
// depends on htfe_pkg, htfe_in_if, htfe_out_if, htfe_core and htfe_fifo
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          rx_byte
//   out_ch   out  valid/ready          frame_byte .. run_last
//   cfg_*    in   cfg_we, no ready     cfg_idx, cfg_data (16 bit)
//
// one byte per cycle while out_ch takes results; a result is queued at the clock edge that takes its byte
// a header match yields two items, queued in a four-entry result queue
// in_ch.ready drops only while the queue has fewer than two free entries
// synchronous active-low reset; header and trailer return to 0x5AA5 / 0xA55A
module header_tail_frame_extractor_unit
  import htfe_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_idx,
  input  logic [15:0] cfg_data,
  htfe_in_if.sink     in_ch,
  htfe_out_if.source  out_ch
);

  push_t   push;
  result_t item;
  logic    room;
  logic    in_fire;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;

  htfe_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .in_byte  (in_ch.rx_byte),
    .push     (push)
  );

  htfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (item)
  );

  assign out_ch.frame_byte    = item.frame_byte;
  assign out_ch.byte_position = item.byte_position;
  assign out_ch.frame_done    = item.frame_done;
  assign out_ch.frame_length  = item.frame_length;
  assign out_ch.frame_abort   = item.frame_abort;
  assign out_ch.run_last      = item.run_last;

endmodule

/* rtl/htfe_core.sv */
// deframer state machine: header hunt, body, trailer detection, overflow abort
// depends on htfe_pkg; emits up to two result items per accepted byte
module htfe_core
  import htfe_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_fire,
  input  logic [7:0]  in_byte,
  output push_t       push
);

  localparam int unsigned CW = $clog2(MAX_FRAME + 1);

  typedef enum logic [1:0] {
    PH_HUNT_HI,
    PH_HUNT_LO,
    PH_BODY,
    PH_TAIL_LO
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   hdr_r, trl_r;

  logic [7:0]  hh, hl, th, tl;
  logic [31:0] count_ext, len_ext;
  logic        full;

  assign hh        = hdr_r[15:8];
  assign hl        = hdr_r[7:0];
  assign th        = trl_r[15:8];
  assign tl        = trl_r[7:0];
  assign count_ext = 32'(count_r);
  assign len_ext   = count_ext + 32'd1;
  assign full      = (count_r >= CW'(MAX_FRAME));

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    push      = '0;
    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT_HI: begin
          if (in_byte == hh) phase_nxt = PH_HUNT_LO;
          count_nxt = '0;
        end
        PH_HUNT_LO: begin
          if (in_byte == hl) begin
            push.cnt              = 2'd2;
            push.r0.frame_byte    = hh;
            push.r1.frame_byte    = hl;
            push.r1.byte_position = 8'd1;
            push.r1.run_last      = 1'b1;
            count_nxt             = CW'(2);
            phase_nxt             = PH_BODY;
          end else begin
            count_nxt = '0;
            phase_nxt = PH_HUNT_HI;
          end
        end
        PH_BODY, PH_TAIL_LO: begin
          push.cnt         = 2'd1;
          push.r0.run_last = 1'b1;
          if (full) begin
            // frame dropped, byte retried as header high
            push.r0.frame_abort = 1'b1;
            count_nxt           = '0;
            phase_nxt           = (in_byte == hh) ? PH_HUNT_LO : PH_HUNT_HI;
          end else begin
            push.r0.frame_byte    = in_byte;
            push.r0.byte_position = count_ext[7:0];
            count_nxt             = CW'(len_ext);
            if (phase_r == PH_TAIL_LO) begin
              if (in_byte == tl) begin
                push.r0.frame_done   = 1'b1;
                push.r0.frame_length = len_ext[8:0];
                count_nxt            = '0;
                phase_nxt            = PH_HUNT_HI;
              end else begin
                phase_nxt = PH_BODY;
              end
            end else if (in_byte == th) begin
              phase_nxt = PH_TAIL_LO;
            end
          end
        end
        default: phase_nxt = PH_HUNT_HI;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_HI;
      count_r <= '0;
      hdr_r   <= HEADER_RST;
      trl_r   <= TRAILER_RST;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_HEADER:  hdr_r <= cfg_data;
          REG_TRAILER: trl_r <= cfg_data;
          default:     hdr_r <= hdr_r;
        endcase
      end
    end
  end

endmodule

/* rtl/htfe_fifo.sv */
// small result queue between the deframer and the result channel
// depends on htfe_pkg; takes up to two items per cycle, gives one
module htfe_fifo
  import htfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  result_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic                 pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign cnt_nxt   = cnt_r + (FIFO_AW + 1)'(push.cnt) - (FIFO_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push.cnt);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
